// ----- hw/rtl/yaz0_pkg.sv -----
// Shared types and constants for the Yaz0 decompressor.
// No dependencies.
package yaz0_pkg;
	localparam int HistDepth = 4096;
	localparam int HistAw = 12;
	localparam int LaneNum = 8;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_GROUP  = 3'd1;
	localparam logic [2:0] PH_ITEM   = 3'd2;
	localparam logic [2:0] PH_REF2   = 3'd3;
	localparam logic [2:0] PH_EXT    = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	localparam logic [0:0] REG_SKIP  = 1'd0;
	localparam logic [0:0] REG_LIMIT = 1'd1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_start;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_data;
		logic [3:0]  byte_count;
		logic        last_of_run;
		logic        stream_done;
	} out_item_t;

	typedef struct packed {
		logic              we;
		logic [HistAw-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [HistAw-1:0] raddr;
	} hist_req_t;
endpackage

// ----- hw/rtl/yaz0_if.sv -----
// Valid/ready channel carrying one payload item.
// Depends on nothing; payload type is given at instantiation.
interface yaz0_if #(parameter type item_t = logic) (input logic clk);
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/yaz0_hist.sv -----
// 4 KiB history memory, one write and one registered read port.
// Depends on yaz0_pkg.
module yaz0_hist (
	input  logic                       clk,
	input  yaz0_pkg::hist_req_t        req,
	output logic [7:0]                 rdata
);
	logic [7:0] mem [yaz0_pkg::HistDepth];

	always_ff @(posedge clk) begin
		if (req.we) mem[req.waddr] <= req.wdata;
		if (req.re) rdata <= mem[req.raddr];
	end
endmodule

// ----- hw/rtl/yaz0_decompressor.sv -----
// Yaz0 decompressor top level: parser, copy sequencer and output packer.
// Depends on yaz0_pkg, yaz0_if, yaz0_hist.
//
// Usage: compressed bytes enter on channel in (in_byte, stream_start), one
// item per handshake. Decoded bytes leave on channel out packed up to eight
// per item, first byte in lane 0; last_of_run marks the final output item
// caused by an input byte, stream_done the one on which the decoded size or
// output limit is reached. skip_count (index 0) and output_limit (index 1)
// are written through cfg_we/cfg_index/cfg_data while idle.
// An emitted literal fills the output register and the next input is
// taken once that item leaves. A back-reference runs one history read,
// then one byte per cycle while out is not stalled (registered read,
// read-to-write forwarding for distance one).
// Input is held off while a copy runs or a result waits.
// A full result waits in the output register; while out is stalled the
// copy pauses, nothing is lost. Reset clears control state and puts the
// parser in the header phase; history contents are undefined until written.
module yaz0_decompressor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	yaz0_if.sink        in,
	yaz0_if.source      out
);
	logic [31:0] skip_q, limit_q;
	logic [2:0]  phase_q;
	logic [3:0]  hidx_q;
	logic [31:0] total_q, dec_q, emit_q;
	logic [7:0]  group_q;
	logic [3:0]  bleft_q;
	logic [11:0] refd_q;
	logic [3:0]  refn_q;
	logic [11:0] hptr_q;
	logic        fin_q;

	logic        copy_q;
	logic [8:0]  clen_q;
	logic [11:0] cdist_q;
	logic        rd_s1;
	logic [7:0]  lastw_q;

	logic [63:0] acc_q;
	logic [3:0]  cnt_q;
	logic        ovalid_q;
	yaz0_pkg::out_item_t obuf_q;

	logic [7:0]  hrdata;
	yaz0_pkg::hist_req_t req;

	yaz0_hist u_hist (.clk(clk), .req(req), .rdata(hrdata));

	logic busy, take;
	assign busy = copy_q || ovalid_q;
	assign in.ready = !busy;
	assign take = in.valid && in.ready;
	assign out.valid = ovalid_q;
	assign out.data = obuf_q;

	// copy paused while a full result waits
	logic stall;
	assign stall = ovalid_q && !out.ready;

	// byte put this cycle
	logic       put_v;
	logic [7:0] put_b;
	logic       copy_byte;
	assign copy_byte = copy_q && rd_s1 && !stall;
	always_comb begin
		put_v = 1'b0;
		put_b = hrdata;
		if (copy_byte) begin
			put_v = 1'b1;
			put_b = (cdist_q == 12'd0) ? lastw_q : hrdata;
		end else if (take && !in.data.stream_start && !fin_q && phase_q == yaz0_pkg::PH_ITEM
			&& group_q[7]) begin
			put_v = 1'b1;
			put_b = in.data.in_byte;
		end
	end

	// put_decoded evaluation
	logic [31:0] dec_n;
	logic        emit_v, fin_put, flush_full;
	always_comb begin
		dec_n = dec_q + 32'd1;
		emit_v = 1'b0;
		fin_put = 1'b0;
		if (dec_n > skip_q) begin
			if (emit_q >= limit_q) fin_put = 1'b1;
			else begin
				emit_v = 1'b1;
				if (emit_q + 32'd1 >= limit_q) fin_put = 1'b1;
			end
		end
		if (!fin_put && dec_n >= total_q) fin_put = 1'b1;
		flush_full = emit_v && (cnt_q == 4'(yaz0_pkg::LaneNum - 1));
	end

	assign req.we = put_v;
	assign req.waddr = hptr_q;
	assign req.wdata = put_b;
	// read next copy byte; distance one is forwarded from lastw_q
	assign req.re = copy_q && !stall;
	assign req.raddr = hptr_q + (put_v ? 12'd1 : 12'd0) - cdist_q - 12'd1;

	logic [63:0] acc_n;
	logic [3:0]  cnt_n;
	always_comb begin
		acc_n = acc_q;
		cnt_n = cnt_q;
		if (emit_v && put_v) begin
			acc_n = acc_q | ({56'd0, put_b} << {cnt_q[2:0], 3'b000});
			cnt_n = cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0; limit_q <= '0;
			phase_q <= yaz0_pkg::PH_HEADER; hidx_q <= '0; total_q <= '0;
			dec_q <= '0; emit_q <= '0; group_q <= '0; bleft_q <= '0;
			refd_q <= '0; refn_q <= '0; hptr_q <= '0; fin_q <= 1'b0;
			copy_q <= 1'b0; clen_q <= '0; cdist_q <= '0; rd_s1 <= 1'b0;
			lastw_q <= '0; acc_q <= '0; cnt_q <= '0; ovalid_q <= 1'b0;
			obuf_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					yaz0_pkg::REG_SKIP:  skip_q <= cfg_data;
					yaz0_pkg::REG_LIMIT: limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (ovalid_q && out.ready) ovalid_q <= 1'b0;

			if (put_v) begin
				hptr_q <= hptr_q + 12'd1;
				lastw_q <= put_b;
				dec_q <= dec_n;
				if (emit_v) emit_q <= emit_q + 32'd1;
			end

			// helpers computed inline below
			if (copy_q && !stall) begin
				rd_s1 <= 1'b1;
			end

			if (take) begin
				logic        st_fin;
				logic        end_it;
				logic [2:0]  ph;
				logic [7:0]  b;
				st_fin = fin_q;
				ph = phase_q;
				b = in.data.in_byte;
				end_it = 1'b0;
				acc_q <= '0; cnt_q <= '0;
				if (in.data.stream_start) begin
					st_fin = 1'b0; ph = yaz0_pkg::PH_HEADER;
					hidx_q <= '0; total_q <= '0; dec_q <= '0; emit_q <= '0;
					group_q <= '0; bleft_q <= '0; refd_q <= '0; refn_q <= '0;
					fin_q <= 1'b0; phase_q <= yaz0_pkg::PH_HEADER;
				end
				if (!st_fin) begin
					unique case (ph)
						yaz0_pkg::PH_HEADER: begin
							logic [31:0] tn;
							tn = in.data.stream_start ? 32'd0 : total_q;
							if (hidx_q >= 4'd4 && hidx_q <= 4'd7) tn = {tn[23:0], b};
							if (in.data.stream_start) begin
								tn = (4'd0 >= 4'd4) ? tn : 32'd0;
							end
							total_q <= tn;
							hidx_q <= (in.data.stream_start ? 4'd0 : hidx_q) + 4'd1;
							if (!in.data.stream_start && hidx_q == 4'd15) begin
								if (tn == 32'd0 || limit_q == 32'd0 || skip_q > tn) begin
									fin_q <= 1'b1; phase_q <= yaz0_pkg::PH_DONE;
								end else phase_q <= yaz0_pkg::PH_GROUP;
							end
						end
						yaz0_pkg::PH_GROUP: begin
							group_q <= b; bleft_q <= 4'd8;
							phase_q <= yaz0_pkg::PH_ITEM;
						end
						yaz0_pkg::PH_ITEM: begin
							if (group_q[7]) begin
								end_it = 1'b1;
								acc_q <= emit_v ? {56'd0, b} : 64'd0;
								cnt_q <= emit_v ? 4'd1 : 4'd0;
								if (fin_put) begin
									fin_q <= 1'b1; phase_q <= yaz0_pkg::PH_DONE;
									end_it = 1'b0;
								end
								ovalid_q <= emit_v;
								obuf_q <= '{out_data: {56'd0, b}, byte_count: 4'd1,
									last_of_run: 1'b1, stream_done: fin_put};
								acc_q <= '0; cnt_q <= '0;
							end else begin
								refn_q <= b[7:4]; refd_q <= {b[3:0], 8'd0};
								phase_q <= yaz0_pkg::PH_REF2;
							end
						end
						yaz0_pkg::PH_REF2: begin
							refd_q <= {refd_q[11:8], b};
							if (refn_q == 4'd0) phase_q <= yaz0_pkg::PH_EXT;
							else begin
								copy_q <= 1'b1; rd_s1 <= 1'b0;
								clen_q <= {5'd0, refn_q} + 9'd2;
								cdist_q <= {refd_q[11:8], b};
							end
						end
						yaz0_pkg::PH_EXT: begin
							copy_q <= 1'b1; rd_s1 <= 1'b0;
							clen_q <= {1'b0, b} + 9'd18;
							cdist_q <= refd_q;
						end
						default: begin
							fin_q <= 1'b1; phase_q <= yaz0_pkg::PH_DONE;
						end
					endcase
					if (end_it) begin
						group_q <= {group_q[6:0], 1'b0};
						bleft_q <= bleft_q - 4'd1;
						phase_q <= (bleft_q == 4'd1) ? yaz0_pkg::PH_GROUP
							: yaz0_pkg::PH_ITEM;
					end
				end
			end else if (copy_byte && !stall) begin
				logic last;
				last = (clen_q == 9'd1) || fin_put;
				acc_q <= flush_full ? 64'd0 : acc_n;
				cnt_q <= flush_full ? 4'd0 : cnt_n;
				clen_q <= clen_q - 9'd1;
				if (flush_full || (last && cnt_n != 4'd0)) begin
					ovalid_q <= 1'b1;
					obuf_q <= '{out_data: acc_n, byte_count: cnt_n,
						last_of_run: last, stream_done: last && fin_put};
				end
				if (last) begin
					copy_q <= 1'b0; rd_s1 <= 1'b0;
					acc_q <= '0; cnt_q <= '0;
					if (fin_put) begin
						fin_q <= 1'b1; phase_q <= yaz0_pkg::PH_DONE;
					end else begin
						group_q <= {group_q[6:0], 1'b0};
						bleft_q <= bleft_q - 4'd1;
						phase_q <= (bleft_q == 4'd1) ? yaz0_pkg::PH_GROUP
							: yaz0_pkg::PH_ITEM;
					end
				end
			end
		end
	end

	property p_no_take_copy;
		@(posedge clk) disable iff (!arst_n) copy_q |-> !in.ready;
	endproperty
	assert property (p_no_take_copy) else $error("input taken during copy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out.ready) |=> ovalid_q)
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> !copy_q || $past(copy_q))
		else $error("copy started after finish");
	// hold history writes while the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> !req.we)
		else $error("history written under stall");
endmodule

// ----- verif/tb_yaz0_decompressor.sv -----
// Testbench for yaz0_decompressor: drives Yaz0 streams and checks every output item.
// A bit-accurate decode predictor in a scoreboard class supplies the expected items.
// Depends on yaz0_pkg, yaz0_if and yaz0_decompressor.
`timescale 1ns / 1ps

module tb_yaz0_decompressor;

	class yaz0_scoreboard;
		logic [31:0] skip_cnt;
		logic [31:0] out_limit;
		logic [2:0]  phase;
		int unsigned hdr_idx;
		logic [31:0] total;
		logic [31:0] decoded;
		logic [31:0] emitted;
		logic [7:0]  grp;
		logic [3:0]  bits;
		logic [11:0] ref_hi;
		logic [7:0]  hist [yaz0_pkg::HistDepth];
		logic [11:0] hptr;
		int unsigned hist_fill;
		bit          done;
		logic [63:0] lane;
		int          lane_n;
		int          step_n;
		yaz0_pkg::out_item_t pending [$];
		int          errors;

		function new();
			skip_cnt = 0;
			out_limit = 0;
			restart();
			hptr = 0;
			hist_fill = 0;
			errors = 0;
		endfunction

		function void restart();
			phase = yaz0_pkg::PH_HEADER;
			hdr_idx = 0;
			total = 0;
			decoded = 0;
			emitted = 0;
			grp = 0;
			bits = 0;
			ref_hi = 0;
			done = 0;
		endfunction

		function void finish();
			done = 1;
			phase = yaz0_pkg::PH_DONE;
		endfunction

		function void flush();
			yaz0_pkg::out_item_t w;
			if (lane_n == 0)
				return;
			w.out_data = lane;
			w.byte_count = lane_n[3:0];
			w.last_of_run = 0;
			w.stream_done = 0;
			pending.push_back(w);
			step_n++;
			lane = 0;
			lane_n = 0;
		endfunction

		function void put_byte(logic [7:0] b);
			hist[hptr] = b;
			hptr = hptr + 12'd1;
			if (hist_fill < yaz0_pkg::HistDepth)
				hist_fill++;
			decoded = decoded + 1;
			if (decoded > skip_cnt) begin
				if (emitted >= out_limit) begin
					finish();
					return;
				end
				lane = lane | (64'(b) << (8 * lane_n));
				lane_n++;
				emitted = emitted + 1;
				if (lane_n >= yaz0_pkg::LaneNum)
					flush();
				if (emitted >= out_limit) begin
					finish();
					return;
				end
			end
			if (decoded >= total)
				finish();
		endfunction

		function void copy(int back_dist, int len);
			logic [11:0] idx;
			for (int i = 0; i < len && !done; i++) begin
				idx = hptr - 12'(back_dist);
				put_byte(hist[idx]);
			end
		endfunction

		function void end_item();
			if (done)
				return;
			grp = grp << 1;
			bits = bits - 4'd1;
			phase = (bits == 0) ? yaz0_pkg::PH_GROUP : yaz0_pkg::PH_ITEM;
		endfunction

		function void note_input(yaz0_pkg::in_item_t it);
			logic [7:0] b;
			bit was_done;
			int back_dist;
			b = it.in_byte;
			lane = 0;
			lane_n = 0;
			step_n = 0;
			if (it.stream_start)
				restart();
			was_done = done;
			if (done)
				return;
			case (phase)
				yaz0_pkg::PH_HEADER: begin
					if (hdr_idx >= 4 && hdr_idx <= 7)
						total = {total[23:0], b};
					hdr_idx = (hdr_idx + 1) & 15;
					if (hdr_idx == 0) begin
						if (total == 0 || out_limit == 0 || skip_cnt > total)
							finish();
						else
							phase = yaz0_pkg::PH_GROUP;
					end
				end
				yaz0_pkg::PH_GROUP: begin
					grp = b;
					bits = 4'd8;
					phase = yaz0_pkg::PH_ITEM;
				end
				yaz0_pkg::PH_ITEM: begin
					if (grp[7]) begin
						put_byte(b);
						end_item();
					end else begin
						ref_hi = {4'd0, b};
						phase = yaz0_pkg::PH_REF2;
					end
				end
				yaz0_pkg::PH_REF2: begin
					if (ref_hi[7:4] == 0) begin
						ref_hi = {ref_hi[3:0], b};
						phase = yaz0_pkg::PH_EXT;
					end else begin
						back_dist = int'({ref_hi[3:0], b}) + 1;
						copy(back_dist, int'(ref_hi[7:4]) + 2);
						end_item();
					end
				end
				yaz0_pkg::PH_EXT: begin
					back_dist = int'(ref_hi) + 1;
					ref_hi = {8'd0, ref_hi[11:8]};
					copy(back_dist, int'(b) + 18);
					end_item();
				end
				default: finish();
			endcase
			flush();
			if (step_n > 0) begin
				pending[pending.size() - 1].last_of_run = 1;
				pending[pending.size() - 1].stream_done = done && !was_done;
			end
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_output(yaz0_pkg::out_item_t got);
			yaz0_pkg::out_item_t exp;
			if (pending.size() == 0) begin
				report($sformatf("unexpected item data=%h", got.out_data));
				return;
			end
			exp = pending.pop_front();
			if (got.out_data !== exp.out_data)
				report($sformatf("out_data %h, want %h", got.out_data, exp.out_data));
			if (got.byte_count !== exp.byte_count)
				report($sformatf("byte_count %0d, want %0d", got.byte_count, exp.byte_count));
			if (got.last_of_run !== exp.last_of_run)
				report($sformatf("last_of_run %b, want %b", got.last_of_run, exp.last_of_run));
			if (got.stream_done !== exp.stream_done)
				report($sformatf("stream_done %b, want %b", got.stream_done, exp.stream_done));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;

	yaz0_if #(.item_t(yaz0_pkg::in_item_t))  in_ch (clk);
	yaz0_if #(.item_t(yaz0_pkg::out_item_t)) out_ch (clk);

	yaz0_decompressor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in        (in_ch),
		.out       (out_ch)
	);

	yaz0_scoreboard sb;
	int          tx_idle_pct;
	int          rx_idle_pct;
	bit          rx_block;
	logic [31:0] hdr_size;
	logic [7:0]  ref_low;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready)
			sb.check_output(out_ch.data);
		out_ch.ready <= !rx_block && ($urandom_range(0, 99) >= rx_idle_pct);
	end

	task hold_receiver(int cycles);
		rx_block <= 1'b1;
		repeat (cycles) @(posedge clk);
		rx_block <= 1'b0;
	endtask

	task send_item(yaz0_pkg::in_item_t it);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(it);
	endtask

	task send_byte(logic [7:0] b, logic start);
		yaz0_pkg::in_item_t it;
		it.in_byte = b;
		it.stream_start = start;
		send_item(it);
	endtask

	task write_reg(logic [0:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == yaz0_pkg::REG_SKIP)
			sb.skip_cnt = val;
		else
			sb.out_limit = val;
	endtask

	task drain();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function logic [31:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 80)
			return 32'($urandom_range(1, 120));
		if (r < 95)
			return 32'($urandom_range(121, 700));
		return $urandom;
	endfunction

	task pick_item(output yaz0_pkg::in_item_t it);
		int r;
		int maxd;
		int back_dist;
		logic [3:0] nib;
		r = $urandom_range(0, 99);
		it.stream_start = 1'b0;
		it.in_byte = 8'($urandom);
		if (sb.done || (r < 2 && sb.phase != yaz0_pkg::PH_HEADER)) begin
			it.stream_start = 1'b1;
			hdr_size = pick_size();
		end else begin
			case (sb.phase)
				yaz0_pkg::PH_HEADER: begin
					if (sb.hdr_idx == 0) begin
						it.stream_start = 1'($urandom_range(0, 1));
						hdr_size = pick_size();
					end else if (sb.hdr_idx >= 4 && sb.hdr_idx <= 7) begin
						it.in_byte = hdr_size[31 - 8 * (sb.hdr_idx - 4) -: 8];
					end
				end
				yaz0_pkg::PH_ITEM: begin
					if (!sb.grp[7]) begin
						maxd = (sb.hist_fill > yaz0_pkg::HistDepth) ? yaz0_pkg::HistDepth
							: sb.hist_fill;
						if (maxd == 0) begin
							it.stream_start = 1'b1;
							hdr_size = pick_size();
						end else begin
							if ($urandom_range(0, 99) < 70)
								back_dist = $urandom_range(1, (maxd < 8) ? maxd : 8);
							else
								back_dist = $urandom_range(1, maxd);
							nib = 4'($urandom_range(0, 15));
							it.in_byte = {nib, 4'((back_dist - 1) >> 8)};
							ref_low = 8'(back_dist - 1);
						end
					end
				end
				yaz0_pkg::PH_REF2: it.in_byte = ref_low;
				yaz0_pkg::PH_EXT: begin
					if (r < 80)
						it.in_byte = 8'($urandom_range(0, 24));
				end
				default: ;
			endcase
		end
		if (it.stream_start && sb.phase == yaz0_pkg::PH_HEADER && sb.hdr_idx == 4)
			it.stream_start = 1'b1;
	endtask

	task run_phase(logic [31:0] skip, logic [31:0] limit, int mode, int hold, int count);
		yaz0_pkg::in_item_t it;
		write_reg(yaz0_pkg::REG_SKIP, skip);
		write_reg(yaz0_pkg::REG_LIMIT, limit);
		tx_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 78 : 0;
		rx_idle_pct = (mode == 0) ? 78 : (mode == 1) ? 16 : 0;
		if (hold > 0)
			fork
				hold_receiver(hold);
			join_none
		for (int n = 0; n < count; n++) begin
			pick_item(it);
			send_item(it);
		end
		drain();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hdr_size = 0;
		ref_low = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(yaz0_pkg::REG_SKIP, 32'd0);
		write_reg(yaz0_pkg::REG_LIMIT, 32'hFFFF_FFFF);
		tx_idle_pct = 16;
		rx_idle_pct = 30;
		// header without start marker, size 20
		send_byte(8'h59, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h7A, 1'b0);
		send_byte(8'h30, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'd20, 1'b0);
		for (int i = 0; i < 8; i++)
			send_byte(8'h00, 1'b0);
		send_byte(8'hA0, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		// extended copy of distance one, cut at the decoded size
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b0);
		drain();

		run_phase(32'd0, 32'hFFFF_FFFF, 0, 0, 58);
		run_phase(32'd7, 32'd50, 1, 0, 58);
		run_phase(32'd0, 32'd0, 2, 0, 58);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 58);
		run_phase(32'd2, 32'd1, 1, 0, 58);
		run_phase(32'd0, 32'hFFFF_FFFF, 2, 3000, 58);

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ----- files.f -----
hw/rtl/yaz0_pkg.sv
hw/rtl/yaz0_if.sv
hw/rtl/yaz0_hist.sv
hw/rtl/yaz0_decompressor.sv
verif/tb_yaz0_decompressor.sv
